// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that holds in every cycle out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Implication, checked every cycle out of reset
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/tmhu_pkg.sv =====
// ----------------------------------------------------------------------------
// tmhu_pkg
// Shared constants, types and helpers for the track median/height update.
// ----------------------------------------------------------------------------
package tmhu_pkg;
	localparam int WINDOW    = 5;
	localparam int POS_WIDTH = 21;
	localparam int WIN_W     = $clog2(WINDOW + 1);
	localparam int MID       = WINDOW / 2;

	typedef logic signed [POS_WIDTH-1:0] pos_t;

	localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
	localparam logic signed [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};
	localparam longint SENT_RAW = -256000;
	localparam longint POS_HI   = (longint'(1) <<< (POS_WIDTH - 1)) - 1;
	localparam pos_t SENT   = (SENT_RAW < -POS_HI - 1) ? POS_MIN : pos_t'(SENT_RAW);
	localparam pos_t SENT_Z = pos_t'(243);

	// register indexes
	localparam logic [2:0] REG_LIM_UNLOCKED = 3'd0;
	localparam logic [2:0] REG_LIM_LOCKED   = 3'd1;
	localparam logic [2:0] REG_MEAS_VAR     = 3'd2;
	localparam logic [2:0] REG_PROC_VAR     = 3'd3;
	localparam logic [2:0] REG_VAR_INIT     = 3'd4;

	localparam logic OP_START = 1'b0;

	typedef struct packed {
		logic load;     // capture item, do start or shift
		logic rank;     // one ranking step
		logic div_go;   // start gain divider
		logic div_step; // one divider step
		logic upd_mul;  // first multiply stage
		logic upd_fin;  // finish height / variance update
	} cmd_t;

	typedef struct packed {
		logic rank_done;
		logic div_done;
		logic is_start;
	} sts_t;

	// saturate a value two bits wider than a position into the position range
	function automatic pos_t pos_sat(input logic signed [POS_WIDTH+1:0] v);
		pos_t r;
		if (v > $signed({{2{POS_MAX[POS_WIDTH-1]}}, POS_MAX}))
			r = POS_MAX;
		else if (v < $signed({{2{POS_MIN[POS_WIDTH-1]}}, POS_MIN}))
			r = POS_MIN;
		else
			r = v[POS_WIDTH-1:0];
		return r;
	endfunction
endpackage

// ===== rtl/tmhu_ctrl.sv =====
// ----------------------------------------------------------------------------
// tmhu_ctrl
// Sequencer: load, median ranking, gain division, height update (not for a start), output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tmhu_ctrl import tmhu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic out_free,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy,
	output logic res_load
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RANK = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		res_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d = S_RANK;
				end
			end
			S_RANK: begin
				cmd.rank = 1'b1;
				if (sts.rank_done) begin
					if (sts.is_start) begin
						state_d = S_OUT;
					end else begin
						cmd.div_go = 1'b1;
						state_d = S_DIV;
					end
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) state_d = S_MUL;
			end
			S_MUL: begin
				cmd.upd_mul = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.upd_fin = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	`ASSERT_IMPLY(a_load_idle, cmd.load, state_q == S_IDLE, "load outside idle")
	`ASSERT_IMPLY(a_div_after, state_q == S_DIV && !sts.div_done, state_d == S_DIV, "div left early")
	`ASSERT_NEXT(a_res_once, res_load, state_q == S_IDLE, "result not closing item")
endmodule

// ===== rtl/tmhu_dp.sv =====
// ----------------------------------------------------------------------------
// tmhu_dp
// Datapath: history window, serial median ranking, restoring gain divider,
// height Kalman update, miss counter and deletion mark.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tmhu_dp import tmhu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic        op,
	input  logic        present,
	input  pos_t        dx,
	input  pos_t        dy,
	input  pos_t        dz,
	input  logic        lock,
	input  logic [15:0] lim_unl,
	input  logic [15:0] lim_lck,
	input  logic [15:0] meas_var,
	input  logic [15:0] proc_var,
	input  logic [15:0] var_init,
	output pos_t        med_x,
	output pos_t        med_y,
	output pos_t        med_z,
	output pos_t        height,
	output logic [15:0] misses,
	output logic        dead,
	output logic        del
);
	pos_t hx_q [WINDOW];
	pos_t hy_q [WINDOW];
	pos_t hz_q [WINDOW];
	pos_t h_q;
	logic [15:0] p_q;
	logic [15:0] miss_q;
	logic del_q, dead_q, start_q, lock_q;

	// ranking: candidate index i, compare against all WINDOW lanes in parallel
	logic [WIN_W-1:0] ri_q;
	pos_t mx_q, my_q, mz_q;
	pos_t cx, cy, cz;
	logic [WIN_W-1:0] lx, ly, lz, ex, ey, ez;

	// divider
	logic [16:0] den_q;
	logic [5:0]  dcnt_q;
	logic [15:0] k_q;

	// multiply stage
	logic signed [POS_WIDTH+18:0] hprod_s1;
	logic [32:0] pprod_s1;

	always_comb begin
		cx = hx_q[0]; cy = hy_q[0]; cz = hz_q[0];
		for (int i = 0; i < WINDOW; i++) begin
			if (ri_q == WIN_W'(i)) begin
				cx = hx_q[i]; cy = hy_q[i]; cz = hz_q[i];
			end
		end
		lx = '0; ly = '0; lz = '0; ex = '0; ey = '0; ez = '0;
		for (int j = 0; j < WINDOW; j++) begin
			if (hx_q[j] < cx) lx = lx + 1'b1;
			if (hy_q[j] < cy) ly = ly + 1'b1;
			if (hz_q[j] < cz) lz = lz + 1'b1;
			if (hx_q[j] == cx) ex = ex + 1'b1;
			if (hy_q[j] == cy) ey = ey + 1'b1;
			if (hz_q[j] == cz) ez = ez + 1'b1;
		end
	end

	// candidate is the median when lt <= MID < lt+eq
	function automatic logic is_mid(input logic [WIN_W-1:0] lt, input logic [WIN_W-1:0] eq);
		logic [WIN_W:0] s;
		s = {1'b0, lt} + {1'b0, eq};
		return ({1'b0, lt} <= (WIN_W+1)'(MID)) && (s > (WIN_W+1)'(MID));
	endfunction

	assign sts.rank_done = (ri_q == WIN_W'(WINDOW - 1));
	assign sts.div_done  = (dcnt_q == 6'd0);
	assign sts.is_start  = start_q;

	logic [16:0] p_add;
	logic signed [POS_WIDTH+1:0] err;
	logic signed [POS_WIDTH+18:0] hsum;
	logic signed [POS_WIDTH+1:0] hnext;
	assign p_add = {1'b0, p_q} + {1'b0, proc_var};
	assign err = ($signed({hz_q[0], 1'b0}) - $signed({{2{h_q[POS_WIDTH-1]}}, h_q}));
	assign hsum = hprod_s1 + $signed((POS_WIDTH+19)'(32768));
	// the correction never exceeds the error, so it fits the error width
	assign hnext = $signed({{2{h_q[POS_WIDTH-1]}}, h_q})
		+ $signed(hsum[POS_WIDTH+17:16]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				hx_q[i] <= SENT; hy_q[i] <= SENT; hz_q[i] <= SENT_Z;
			end
			h_q <= '0;
			p_q <= 16'd6554;
			miss_q <= '0;
			del_q <= 1'b0;
			dead_q <= 1'b0;
			start_q <= 1'b0;
			lock_q <= 1'b0;
			ri_q <= '0;
			dcnt_q <= '0;
		end else begin
			if (cmd.load) begin
				start_q <= (op == OP_START);
				lock_q <= lock;
				ri_q <= '0;
				if (op == OP_START) begin
					hx_q[0] <= dx; hy_q[0] <= dy; hz_q[0] <= dz;
					for (int i = 1; i < WINDOW; i++) begin
						hx_q[i] <= SENT; hy_q[i] <= SENT; hz_q[i] <= SENT_Z;
					end
					h_q <= pos_sat({dz[POS_WIDTH-1], dz, 1'b0});
					p_q <= var_init;
					miss_q <= '0;
					del_q <= 1'b0;
					dead_q <= 1'b0;
				end else begin
					p_q <= p_add[16] ? 16'hFFFF : p_add[15:0];
					for (int i = 1; i < WINDOW; i++) begin
						hx_q[i] <= hx_q[i-1]; hy_q[i] <= hy_q[i-1]; hz_q[i] <= hz_q[i-1];
					end
					dead_q <= !present;
					if (present) begin
						hx_q[0] <= dx; hy_q[0] <= dy; hz_q[0] <= dz;
						miss_q <= '0;
					end else begin
						hx_q[0] <= SENT; hy_q[0] <= SENT; hz_q[0] <= SENT_Z;
						if (miss_q != 16'hFFFF) miss_q <= miss_q + 16'd1;
					end
				end
			end
			if (cmd.rank && !sts.rank_done) ri_q <= ri_q + 1'b1;
			if (cmd.div_go) dcnt_q <= 6'd34;
			else if (cmd.div_step && dcnt_q != 6'd0) dcnt_q <= dcnt_q - 6'd1;
			if (cmd.upd_fin) begin
				h_q <= pos_sat(hnext);
				if ((lock_q ? lim_lck : lim_unl) < miss_q) del_q <= 1'b1;
			end
			if (cmd.upd_fin) p_q <= 16'(((pprod_s1 + 33'd32768) >> 16));
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mx_q <= SENT; my_q <= SENT; mz_q <= SENT_Z;
		end
		if (cmd.rank) begin
			if (is_mid(lx, ex)) mx_q <= cx;
			if (is_mid(ly, ey)) my_q <= cy;
			if (is_mid(lz, ez)) mz_q <= cz;
		end
		if (cmd.div_go) den_q <= {1'b0, p_q} + {1'b0, meas_var};
		if (cmd.upd_mul) begin
			hprod_s1 <= $signed({1'b0, k_q}) * err;
			pprod_s1 <= (33'd65536 - {17'd0, k_q}) * {17'd0, p_q};
		end
	end

	// restoring division of (P<<16)+den/2 by den, one quotient bit per step;
	// numerator sits in a shift register, partial remainder beside it
	logic [33:0] num_q;
	logic [17:0] prem_q;
	logic [33:0] qbits_q;
	logic [17:0] trial;
	assign trial = {prem_q[16:0], num_q[33]} - {1'b0, den_q};
	always_ff @(posedge clk) begin
		if (cmd.div_step && dcnt_q == 6'd34) begin
			num_q <= {1'b0, {p_q, 16'd0} + {16'd0, den_q[16:1]}, 1'b0};
			prem_q <= '0;
			qbits_q <= '0;
		end else if (cmd.div_step && dcnt_q != 6'd0) begin
			num_q <= {num_q[32:0], 1'b0};
			if (!trial[17]) begin
				prem_q <= trial;
				qbits_q <= {qbits_q[32:0], 1'b1};
			end else begin
				prem_q <= {prem_q[16:0], num_q[33]};
				qbits_q <= {qbits_q[32:0], 1'b0};
			end
		end
	end
	// 32-bit numerator is loaded one place up, so 33 shifts bring in every bit
	always_comb begin
		if (den_q == 17'd0) k_q = '0;
		else if (qbits_q[33:16] != '0) k_q = 16'hFFFF;
		else k_q = qbits_q[15:0];
	end

	assign med_x = mx_q;
	assign med_y = my_q;
	assign med_z = mz_q;
	assign height = h_q;
	assign misses = miss_q;
	assign dead = dead_q;
	assign del = del_q && !start_q;

	`ASSERT_NEXT(a_miss_clear, cmd.load && op == OP_START, miss_q == 16'd0, "miss not cleared")
	`ASSERT_NEXT(a_dead_miss, cmd.load && op != OP_START && !present, dead_q, "dead not set")
	`ASSERT_IMPLY(a_rank_range, cmd.rank, ri_q < WIN_W'(WINDOW), "rank index overrun")
endmodule

// ===== rtl/track_median_height_update.sv =====
// ----------------------------------------------------------------------------
// track_median_height_update
// Per-frame median history and height filter for one track.
// ----------------------------------------------------------------------------
// Usage: one input transfer per frame on s_axis (start or frame update), one
// result transfer on m_axis per input. Registers are written on cfg while the
// block is idle; cfg_ready is low while an item is being worked.
// Sequence: the input transfer, the ranking of each window candidate, then for
// a frame update the divider steps (operand load, 33 quotient bits, done) and a
// multiply and an update step; a start goes from ranking straight to output.
// The serial gain divider sets the rate. A new input is taken once the previous
// result has moved to the output register, so a stalled receiver holds at most
// one result while the next item is being worked. Reset loads the sentinel
// history, clears counts and height and restores register defaults.
// ----------------------------------------------------------------------------
module track_median_height_update import tmhu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: det_present, det_x, det_y, det_z, locked, zero pad (72 bits)
	input  logic [71:0] s_axis_tdata,
	// tuser: operation
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: median_x, median_y, median_z, meas_valid, height_est, miss_count,
	// dead_reckoning, delete_track, zero pad (104 bits)
	output logic [103:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	cmd_t cmd;
	sts_t sts;
	logic busy, res_load, in_fire, out_free;
	logic [15:0] lim_unl_q, lim_lck_q, meas_q, proc_q, init_q;
	pos_t mx, my, mz, ht;
	logic [15:0] mc;
	logic dd, dl, mv;
	logic [103:0] res_q;
	logic ovalid_q;

	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_free = !ovalid_q || m_axis_tready;
	assign cfg_ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_unl_q <= 16'd10; lim_lck_q <= 16'd30; meas_q <= 16'd957;
			proc_q <= 16'd0; init_q <= 16'd6554;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LIM_UNLOCKED: lim_unl_q <= cfg_data;
				REG_LIM_LOCKED:   lim_lck_q <= cfg_data;
				REG_MEAS_VAR:     meas_q <= cfg_data;
				REG_PROC_VAR:     proc_q <= cfg_data;
				REG_VAR_INIT:     init_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tmhu_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .out_free, .sts, .cmd, .busy, .res_load
	);

	tmhu_dp u_dp (
		.clk, .arst_n, .cmd, .sts,
		.op(s_axis_tuser), .present(s_axis_tdata[0]),
		.dx(s_axis_tdata[21:1]), .dy(s_axis_tdata[42:22]), .dz(s_axis_tdata[63:43]),
		.lock(s_axis_tdata[64]),
		.lim_unl(lim_unl_q), .lim_lck(lim_lck_q), .meas_var(meas_q),
		.proc_var(proc_q), .var_init(init_q),
		.med_x(mx), .med_y(my), .med_z(mz), .height(ht), .misses(mc),
		.dead(dd), .del(dl)
	);

	assign mv = (mx != SENT) && (my != SENT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovalid_q <= 1'b0;
		else if (res_load) ovalid_q <= 1'b1;
		else if (m_axis_tready) ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load) res_q <= {1'b0, dl, dd, mc, ht, mv, mz, my, mx};
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = res_q;
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for track_median_height_update: directed rows, then
// random track sequences across register settings, every result checked
// against a bit-exact model of the median history and height filter.
// ----------------------------------------------------------------------------
module tb import tmhu_pkg::*; ();

	localparam logic [2:0] REG_UNUSED = 3'd5;
	localparam int SENT_I = -256000;
	localparam int PMAX   = 1048575;
	localparam int PMIN   = -1048576;
	localparam int SETTLE = 60;

	typedef struct {
		int  mx, my, mz;
		bit  valid;
		int  height;
		int  miss;
		bit  dead, del;
	} track_out_t;

	typedef struct {
		bit  op;
		bit  pres;
		int  x, y, z;
		bit  lck;
		bit  typed;
		int  mx, my, mz;
		bit  valid;
		int  miss;
		bit  dead, del;
	} stim_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [71:0]  s_axis_tdata = '0;
	logic         s_axis_tuser = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [103:0] m_axis_tdata;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [2:0]   cfg_index = '0;
	logic [15:0]  cfg_data = '0;

	track_median_height_update DUT (.*);

	always #2 clk = ~clk;

	// model state
	int      hx[WINDOW], hy[WINDOW], hz[WINDOW];
	longint  h_val, h_var;
	int      missed;
	bit      del_mark;
	longint  lim_unl, lim_lck, meas_var, proc_var, var_init;

	track_out_t expected_results[$];
	stim_row_t  typed_rows[$];
	bit         typed_flags[$];
	int  errors = 0, n_items = 0, n_results = 0, n_deletes = 0;
	bit  calm = 1'b0;
	int  stall_left = 0;

	function automatic int sat_pos(longint v);
		if (v > PMAX) return PMAX;
		if (v < PMIN) return PMIN;
		return int'(v);
	endfunction

	function automatic int median5(int a[WINDOW]);
		int t[WINDOW];
		int i, j, v;
		for (i = 0; i < WINDOW; i++) begin
			v = a[i];
			j = i;
			while (j > 0 && t[j-1] > v) begin
				t[j] = t[j-1];
				j--;
			end
			t[j] = v;
		end
		return t[MID];
	endfunction

	function automatic void reset_track();
		for (int i = 0; i < WINDOW; i++) begin
			hx[i] = SENT_I; hy[i] = SENT_I; hz[i] = 243;
		end
		lim_unl = 10; lim_lck = 30; meas_var = 957; proc_var = 0; var_init = 6554;
		h_val = 0; h_var = var_init; missed = 0; del_mark = 0;
	endfunction

	function automatic void write_reg(logic [2:0] idx, logic [15:0] d);
		case (idx)
			REG_LIM_UNLOCKED: lim_unl = d;
			REG_LIM_LOCKED:   lim_lck = d;
			REG_MEAS_VAR:     meas_var = d;
			REG_PROC_VAR:     proc_var = d;
			REG_VAR_INIT:     var_init = d;
			default: ;
		endcase
	endfunction

	function automatic track_out_t predict_track(bit op, bit pres, int x, int y, int z,
			bit lck);
		track_out_t r;
		longint den, k, e, prod;
		bit dead = 0;
		if (op == OP_START) begin
			hx[0] = x; hy[0] = y; hz[0] = z;
			for (int i = 1; i < WINDOW; i++) begin
				hx[i] = SENT_I; hy[i] = SENT_I; hz[i] = 243;
			end
			h_val = sat_pos(2 * longint'(z));
			h_var = var_init; missed = 0; del_mark = 0;
		end else begin
			h_var = h_var + proc_var;
			if (h_var > 65535) h_var = 65535;
			for (int i = WINDOW - 1; i > 0; i--) begin
				hx[i] = hx[i-1]; hy[i] = hy[i-1]; hz[i] = hz[i-1];
			end
			if (pres) begin
				hx[0] = x; hy[0] = y; hz[0] = z; missed = 0;
			end else begin
				hx[0] = SENT_I; hy[0] = SENT_I; hz[0] = 243;
				if (missed < 65535) missed++;
				dead = 1;
			end
			den = h_var + meas_var;
			k = 0;
			if (den != 0) begin
				k = ((h_var <<< 16) + den / 2) / den;
				if (k > 65535) k = 65535;
			end
			e = 2 * longint'(hz[0]) - h_val;
			prod = k * e + 32768;
			h_val = sat_pos(h_val + (prod >>> 16));
			h_var = ((65536 - k) * h_var + 32768) >> 16;
			if (missed > (lck ? lim_lck : lim_unl)) del_mark = 1;
		end
		r.mx = median5(hx); r.my = median5(hy); r.mz = median5(hz);
		r.valid = !(r.mx == SENT_I || r.my == SENT_I);
		r.height = int'(h_val);
		r.miss = missed;
		r.dead = dead;
		r.del = (op != OP_START) && del_mark;
		return r;
	endfunction

	function automatic void queue_expect(track_out_t e, bit tf, stim_row_t row);
		expected_results = {expected_results, e};
		typed_flags = {typed_flags, tf};
		typed_rows = {typed_rows, row};
	endfunction

	function automatic void note_mismatch(string what, longint exp_v, longint act_v);
		errors++;
		if (errors <= 10)
			$display("mismatch on result %0d, %s: expected %0d, got %0d",
				n_results, what, exp_v, act_v);
	endfunction

	// result checking
	always @(posedge clk) begin
		track_out_t e, a;
		stim_row_t t;
		bit tf;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			a.mx     = int'(pos_t'(m_axis_tdata[20:0]));
			a.my     = int'(pos_t'(m_axis_tdata[41:21]));
			a.mz     = int'(pos_t'(m_axis_tdata[62:42]));
			a.valid  = m_axis_tdata[63];
			a.height = int'(pos_t'(m_axis_tdata[84:64]));
			a.miss   = int'(m_axis_tdata[100:85]);
			a.dead   = m_axis_tdata[101];
			a.del    = m_axis_tdata[102];
			if (a.del) n_deletes++;
			if (expected_results.size() == 0) begin
				note_mismatch("unexpected result", 0, 1);
			end else begin
				e = expected_results.pop_front();
				tf = typed_flags.pop_front();
				t = typed_rows.pop_front();
				if (a.mx != e.mx) note_mismatch("median_x", e.mx, a.mx);
				if (a.my != e.my) note_mismatch("median_y", e.my, a.my);
				if (a.mz != e.mz) note_mismatch("median_z", e.mz, a.mz);
				if (a.valid != e.valid) note_mismatch("meas_valid", e.valid, a.valid);
				if (a.height != e.height) note_mismatch("height_est", e.height, a.height);
				if (a.miss != e.miss) note_mismatch("miss_count", e.miss, a.miss);
				if (a.dead != e.dead) note_mismatch("dead_reckoning", e.dead, a.dead);
				if (a.del != e.del) note_mismatch("delete_track", e.del, a.del);
				if (tf && (a.mx != t.mx || a.my != t.my || a.mz != t.mz ||
						a.valid != t.valid || a.miss != t.miss || a.dead != t.dead ||
						a.del != t.del))
					note_mismatch("directed row fields", 1, 0);
			end
			n_results++;
		end
		// receiver stalls in bursts
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (arst_n && !calm && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 15);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic send_frame(bit op, bit pres, int x, int y, int z, bit lck,
			bit typed, stim_row_t row);
		int gap;
		if (!calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 16);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {7'd0, lck, z[20:0], y[20:0], x[20:0], pres};
		do @(posedge clk); while (!s_axis_tready);
		queue_expect(predict_track(op, pres, x, y, z, lck), typed, row);
		n_items++;
	endtask

	task automatic go_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(logic [2:0] idx, logic [15:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		write_reg(idx, d);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(int ph);
		logic [15:0] v[5];
		case (ph)
			0: v = '{16'd0, 16'd0, 16'd1, 16'd0, 16'd0};
			1: v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
			5: v = '{16'd10, 16'd30, 16'd957, 16'd0, 16'd6554};
			default: v = '{16'($urandom_range(0, 40)), 16'($urandom_range(0, 60)),
				16'($urandom_range(1, 65535)), 16'($urandom_range(0, 3000)),
				16'($urandom)};
		endcase
		cfg_write(REG_LIM_UNLOCKED, v[0]);
		cfg_write(REG_LIM_LOCKED, v[1]);
		cfg_write(REG_MEAS_VAR, v[2]);
		cfg_write(REG_PROC_VAR, v[3]);
		cfg_write(REG_VAR_INIT, v[4]);
		cfg_write(REG_UNUSED, 16'($urandom));
	endtask

	function automatic int any_pos();
		return int'(pos_t'($urandom));
	endfunction

	stim_row_t directed[23] = '{
		'{1, 0, 0, 0, 0, 0, 1, SENT_I, SENT_I, 243, 0, 1, 1, 0},
		'{1, 0, 0, 0, 0, 0, 1, SENT_I, SENT_I, 243, 0, 2, 1, 0},
		'{0, 1, 0, 0, 0, 0, 1, SENT_I, SENT_I, 243, 0, 0, 0, 0},
		'{0, 1, PMAX, PMAX, PMAX, 0, 1, SENT_I, SENT_I, 243, 0, 0, 0, 0},
		'{1, 1, PMIN, PMIN, PMIN, 0, 1, SENT_I, SENT_I, 243, 0, 0, 0, 0},
		'{1, 1, 256, 512, 230, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{1, 1, 260, 515, 231, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{1, 1, SENT_I, 520, 232, 1, 0, 0, 0, 0, 0, 0, 0, 0},
		'{1, 1, 270, 530, 228, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{1, 0, 0, 0, 0, 0, 1, SENT_I, SENT_I, 243, 0, 12, 1, 1},
		'{1, 1, 100, 100, 240, 1, 0, 0, 0, 0, 0, 0, 0, 0},
		'{0, 0, -5, -5, -5, 1, 1, SENT_I, SENT_I, 243, 0, 0, 0, 0}
	};

	initial begin
		stim_row_t none;
		int bx, by, bz, x, y, z, len, run;
		bit lck, pres;
		none = directed[0];
		reset_track();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_frame(directed[i].op, directed[i].pres, directed[i].x, directed[i].y,
				directed[i].z, directed[i].lck, directed[i].typed, directed[i]);

		for (int ph = 0; ph < 6; ph++) begin
			go_idle();
			if (ph == 5) calm = 1'b1;
			apply_setting(ph);
			while (n_items < 23 + (ph + 1) * 305) begin
				// one track: a start, then a run of frames with drift and dropouts
				bx = $urandom_range(0, 9) == 0 ? any_pos() : $urandom_range(0, 4000) - 2000;
				by = $urandom_range(0, 9) == 0 ? any_pos() : $urandom_range(0, 4000) - 2000;
				bz = $urandom_range(0, 9) == 0 ? any_pos() : $urandom_range(200, 260);
				lck = $urandom_range(0, 1);
				send_frame(OP_START, $urandom_range(0, 1), bx, by, bz, lck, 0, none);
				len = $urandom_range(5, 60);
				run = 0;
				for (int f = 0; f < len; f++) begin
					if (run == 0 && $urandom_range(0, 9) < 2) run = $urandom_range(1, 40);
					pres = (run == 0);
					if (run > 0) run--;
					bx = sat_pos(longint'(bx) + int'($urandom_range(0, 40)) - 20);
					by = sat_pos(longint'(by) + int'($urandom_range(0, 40)) - 20);
					bz = sat_pos(longint'(bz) + int'($urandom_range(0, 6)) - 3);
					x = bx; y = by; z = bz;
					case ($urandom_range(0, 39))
						0: begin x = any_pos(); y = any_pos(); z = any_pos(); end
						1: x = SENT_I;
						2: y = SENT_I;
						default: ;
					endcase
					if ($urandom_range(0, 19) == 0) lck = ~lck;
					send_frame(1'b1, pres, pres ? x : any_pos(), pres ? y : any_pos(),
						pres ? z : any_pos(), lck, 0, none);
				end
			end
		end

		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		$display("covered %0d items and %0d results over six register settings,",
			n_items, n_results);
		$display("%0d results flagged delete, %0d mismatches", n_deletes, errors);
		if (errors == 0)
			$display("track_median_height_update regression: pass");
		else
			$display("track_median_height_update regression: fail");
		$finish;
	end

	initial begin
		#5ms;
		$display("timeout waiting on transfers");
		$display("track_median_height_update regression: fail");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/tmhu_pkg.sv
rtl/tmhu_ctrl.sv
rtl/tmhu_dp.sv
rtl/track_median_height_update.sv
tb/sv/tb.sv
